@@ hdl/dpd_pkg.sv @@
// Package for the debug packet deframer: framing characters, phase and
// status codes, the result record and the hex digit decoder.
// No dependencies.
package dpd_pkg;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [3:0] HEX_TEN  = 4'hA;

    // parser phases
    localparam logic [2:0] PH_ACK     = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_HEX_HI  = 3'd3;
    localparam logic [2:0] PH_HEX_LO  = 3'd4;
    localparam logic [2:0] PH_STOPPED = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_ACK    = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_BAD_HEX   = 3'd3;
    localparam logic [2:0] ST_DAMAGED   = 3'd4;
    localparam logic [2:0] ST_STOPPED   = 3'd5;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       packet_done;
        logic       packet_good;
        logic       send_reply;
        logic [7:0] reply_char;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_sum;
        logic [3:0] high_nibble;
    } parse_state_t;

    typedef struct packed {
        logic       bad;    // not a hex digit
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.bad   = 1'b0;
        d.value = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // 'a'/'A' have low bits 1, so value = low bits - 1 + 10
            d.value = c[3:0] - 4'd1 + HEX_TEN;
        end
        else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

@@ hdl/debug_packet_deframer.sv @@
// Top level of the debug packet deframer: input byte register, parser
// state, result register and the ack_mode register. Uses dpd_pkg, dpd_parse.
//
//   channel  dir  handshake              payload
//   rx       in   rx_valid / rx_ready    rx_byte
//   out      out  out_valid / out_ready  payload_valid .. status
//   cfg      in   cfg_valid / cfg_ready  ack_mode
//
// One byte per cycle sustained while out does not stall; an rx beat reaches out
// through the input register, then parse into the result register.
// Parser state updates as a byte moves from the input to the result register.
// rst_n clears phase to await the initial '+', sum and nibble to zero,
// ack_mode to 1. A stall on out holds both stages; rx_ready drops only when
// both are full. cfg is always ready.
module debug_packet_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic       packet_done,
    output logic       packet_good,
    output logic       send_reply,
    output logic [7:0] reply_char,
    output logic [2:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       ack_mode
);

    logic                  ack_mode_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg;
    dpd_pkg::result_t      res_reg;
    dpd_pkg::result_t      res_next;
    dpd_pkg::parse_state_t state_reg;
    dpd_pkg::parse_state_t state_next;
    logic                  out_adv;
    logic                  in_move;

    assign out_adv  = !out_valid_reg || out_ready;
    assign in_move  = in_valid_reg && out_adv;
    assign rx_ready = !in_valid_reg || out_adv;
    assign cfg_ready = 1'b1;

    dpd_parse u_parse
    (
        .cur      (state_reg),
        .rx_byte  (in_byte_reg),
        .ack_mode (ack_mode_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ack_mode_reg          <= 1'b1;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= dpd_pkg::PH_ACK;
            state_reg.running_sum <= 8'h00;
            state_reg.high_nibble <= 4'h0;
        end
        else begin
            if (cfg_valid) begin
                ack_mode_reg <= ack_mode;
            end
            if (rx_ready) begin
                in_valid_reg <= rx_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_move) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid) begin
            in_byte_reg <= rx_byte;
        end
        if (in_move) begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = res_reg.payload_valid;
    assign payload_byte  = res_reg.payload_byte;
    assign packet_done   = res_reg.packet_done;
    assign packet_good   = res_reg.packet_good;
    assign send_reply    = res_reg.send_reply;
    assign reply_char    = res_reg.reply_char;
    assign status        = res_reg.status;

endmodule

@@ hdl/dpd_parse.sv @@
// Next-state and result logic of the deframer for one received byte.
// Depends on dpd_pkg.
module dpd_parse
(
    input  dpd_pkg::parse_state_t cur,
    input  logic [7:0]            rx_byte,
    input  logic                  ack_mode,
    output dpd_pkg::parse_state_t nxt,
    output dpd_pkg::result_t      res
);

    dpd_pkg::hex_digit_t hd;
    logic [7:0]          expected;

    assign hd       = dpd_pkg::hex_decode(rx_byte);
    assign expected = {cur.high_nibble, hd.value};

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.status = dpd_pkg::ST_OK;
        unique case (cur.phase)
            dpd_pkg::PH_ACK:
            begin
                if (rx_byte == dpd_pkg::CH_PLUS) begin
                    nxt.phase = dpd_pkg::PH_START;
                end
                else begin
                    res.status = dpd_pkg::ST_NO_ACK;
                    nxt.phase  = dpd_pkg::PH_STOPPED;
                end
            end
            dpd_pkg::PH_START:
            begin
                if (rx_byte == dpd_pkg::CH_START) begin
                    nxt.running_sum = 8'h00;
                    nxt.phase       = dpd_pkg::PH_PAYLOAD;
                end
                else begin
                    res.status = dpd_pkg::ST_BAD_START;
                    nxt.phase  = dpd_pkg::PH_STOPPED;
                end
            end
            dpd_pkg::PH_PAYLOAD:
            begin
                if (rx_byte == dpd_pkg::CH_HASH) begin
                    nxt.phase = dpd_pkg::PH_HEX_HI;
                end
                else begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_byte;
                    nxt.running_sum   = cur.running_sum + rx_byte;
                end
            end
            dpd_pkg::PH_HEX_HI:
            begin
                if (hd.bad) begin
                    res.status = dpd_pkg::ST_BAD_HEX;
                    nxt.phase  = dpd_pkg::PH_STOPPED;
                end
                else begin
                    nxt.high_nibble = hd.value;
                    nxt.phase       = dpd_pkg::PH_HEX_LO;
                end
            end
            dpd_pkg::PH_HEX_LO:
            begin
                if (hd.bad) begin
                    res.status = dpd_pkg::ST_BAD_HEX;
                    nxt.phase  = dpd_pkg::PH_STOPPED;
                end
                else begin
                    res.packet_done = 1'b1;
                    nxt.phase       = dpd_pkg::PH_START;
                    if (expected == cur.running_sum) begin
                        res.packet_good = 1'b1;
                        if (ack_mode) begin
                            res.send_reply = 1'b1;
                            res.reply_char = dpd_pkg::CH_PLUS;
                        end
                    end
                    else if (ack_mode) begin
                        // nak only, packet rejected
                        res.send_reply = 1'b1;
                        res.reply_char = dpd_pkg::CH_MINUS;
                    end
                    else if (expected == 8'h00) begin
                        // no-ack mode: zero checksum field is a wildcard
                        res.packet_good = 1'b1;
                    end
                    else begin
                        res.status = dpd_pkg::ST_DAMAGED;
                        nxt.phase  = dpd_pkg::PH_STOPPED;
                    end
                end
            end
            default:
            begin
                res.status = dpd_pkg::ST_STOPPED;
                nxt.phase  = dpd_pkg::PH_STOPPED;
            end
        endcase
    end

endmodule

@@ hdl/dpd_checker.sv @@
// Port-level checks for debug_packet_deframer, attached by bind.
// Depends on dpd_pkg.
module dpd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic       packet_done,
    input logic       packet_good,
    input logic       send_reply,
    input logic [7:0] reply_char,
    input logic [2:0] status
);

    logic stopped_reg;

    // any error status is sticky
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stopped_reg <= 1'b0;
        end
        else if (out_valid && out_ready && status != dpd_pkg::ST_OK) begin
            stopped_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(payload_byte) && $stable(packet_done))
        else $error("out beat changed while stalled");

    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped_reg |-> status == dpd_pkg::ST_STOPPED
            && !payload_valid && !packet_done && !send_reply)
        else $error("beat after error is not stopped status");

    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_reply |-> packet_done && status == dpd_pkg::ST_OK
            && (reply_char == dpd_pkg::CH_PLUS || reply_char == dpd_pkg::CH_MINUS)
            && (packet_good == (reply_char == dpd_pkg::CH_PLUS)))
        else $error("reply inconsistent with packet result");

    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> !packet_done && !packet_good
            && !send_reply && status == dpd_pkg::ST_OK)
        else $error("payload beat carries packet result");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (.*);
